// ----- hw/rtl/qvr_pkg.sv -----
// Shared widths, pipeline stage map and input helper for the quaternion
// vector rotate unit. No dependencies.
package qvr_pkg;

  localparam int QUAT_W         = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int VEC_IN_W       = 16;
  localparam int VEC_WIDTH      = 16;
  localparam int LEN_FRAC       = 14;
  localparam int OUT_W          = 18;

  // vector bits actually read from each 16-bit field
  localparam int VEC_EFF_W = (VEC_WIDTH < VEC_IN_W) ? VEC_WIDTH : VEC_IN_W;

  localparam int PROD_W = QUAT_W + VEC_IN_W;     // q * v products
  localparam int T_W    = PROD_W + 1;            // t = q * (0,v)
  localparam int S_W    = 2 * QUAT_W + 1;        // sum of squares
  localparam int TQ_W   = T_W + QUAT_W;          // t * conj(q) products
  localparam int P_W    = TQ_W + 1;              // signed vector part
  localparam int MAG_W  = P_W - 1;

  // integer square root of S << (2*LEN_FRAC), one result bit per stage
  localparam int SQ_STEPS = (S_W + 2 * LEN_FRAC + 1) / 2;
  localparam int SQN_W    = 2 * SQ_STEPS;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int REM_W    = ROOT_W + 3;

  // restoring division, one quotient bit per stage
  localparam int NUM_W = MAG_W + LEN_FRAC;
  localparam int DEN_W = ROOT_W + QUAT_FRAC_BITS;
  localparam int DIV_W = ((NUM_W > DEN_W + OUT_W) ? NUM_W : DEN_W + OUT_W) + 1;

  localparam logic [OUT_W:0] SAT_POS     = (OUT_W + 1)'((1 << (OUT_W - 1)) - 1);
  localparam logic [OUT_W:0] SAT_NEG_MAG = (OUT_W + 1)'(1 << (OUT_W - 1));

  // stage map: 0 products, 1 sums, 2 products, 3 sums, 4 root setup, then root steps,
  // then division setup, quotient steps, output register
  localparam int ST_SQ0  = 4;
  localparam int ST_DV0  = ST_SQ0 + SQ_STEPS + 1;
  localparam int ST_LAST = ST_DV0 + OUT_W + 1;
  localparam int N_STG   = ST_LAST + 1;

  function automatic logic signed [VEC_IN_W-1:0] vec_ext(input logic [VEC_IN_W-1:0] raw);
    logic signed [VEC_EFF_W-1:0] low;
    low = $signed(raw[VEC_EFF_W-1:0]);
    return VEC_IN_W'(low);
  endfunction

endpackage

// ----- hw/rtl/quaternion_vector_rotate_unit.sv -----
// Channel  Handshake                 Payload
// in       in_valid / in_ready       quat_w..quat_z (Q1.14), vec_x..vec_z
// out      out_valid / out_ready     out_x, out_y, out_z (18b sat), degenerate
//
// One item per cycle sustained while the output is not stalled.
// Depth is set by the square root (31 stages, one root bit each) and the
// divider (18 stages, one quotient bit each, three lanes).
// rst is synchronous and clears the valid bits only.
// A stall at the output freezes the whole pipe; in_ready follows it.
// Depends on qvr_pkg.
module quaternion_vector_rotate_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [qvr_pkg::QUAT_W-1:0]      quat_w,
  input  logic signed [qvr_pkg::QUAT_W-1:0]      quat_x,
  input  logic signed [qvr_pkg::QUAT_W-1:0]      quat_y,
  input  logic signed [qvr_pkg::QUAT_W-1:0]      quat_z,
  input  logic signed [qvr_pkg::VEC_IN_W-1:0]    vec_x,
  input  logic signed [qvr_pkg::VEC_IN_W-1:0]    vec_y,
  input  logic signed [qvr_pkg::VEC_IN_W-1:0]    vec_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [qvr_pkg::OUT_W-1:0]       out_x,
  output logic signed [qvr_pkg::OUT_W-1:0]       out_y,
  output logic signed [qvr_pkg::OUT_W-1:0]       out_z,
  output logic                                   degenerate
);
  import qvr_pkg::*;

  logic adv;
  logic vld [0:N_STG-1];

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[ST_LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_STG; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < N_STG; i++) vld[i] <= vld[i-1];
    end
  end

  // stage 0: q*v products and squares
  logic signed [VEC_IN_W-1:0] vx, vy, vz;
  logic signed [QUAT_W-1:0]   s0_q [0:3];
  logic signed [PROD_W-1:0]   s0_m [0:11];
  logic signed [PROD_W-1:0]   s0_sq [0:3];

  assign vx = vec_ext(vec_x);
  assign vy = vec_ext(vec_y);
  assign vz = vec_ext(vec_z);

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_q[0]  <= quat_w;
      s0_q[1]  <= quat_x;
      s0_q[2]  <= quat_y;
      s0_q[3]  <= quat_z;
      s0_m[0]  <= quat_x * vx;
      s0_m[1]  <= quat_y * vy;
      s0_m[2]  <= quat_z * vz;
      s0_m[3]  <= quat_w * vx;
      s0_m[4]  <= quat_y * vz;
      s0_m[5]  <= quat_z * vy;
      s0_m[6]  <= quat_w * vy;
      s0_m[7]  <= quat_x * vz;
      s0_m[8]  <= quat_z * vx;
      s0_m[9]  <= quat_w * vz;
      s0_m[10] <= quat_x * vy;
      s0_m[11] <= quat_y * vx;
      s0_sq[0] <= quat_w * quat_w;
      s0_sq[1] <= quat_x * quat_x;
      s0_sq[2] <= quat_y * quat_y;
      s0_sq[3] <= quat_z * quat_z;
    end
  end

  // stage 1: t = q * (0,v), S = |q|^2
  logic signed [QUAT_W-1:0] s1_q [0:3];
  logic signed [T_W-1:0]    s1_t [0:3];
  logic [S_W-1:0]           s1_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) s1_q[i] <= s0_q[i];
      s1_t[0] <= -T_W'(s0_m[0]) - T_W'(s0_m[1]) - T_W'(s0_m[2]);
      s1_t[1] <= T_W'(s0_m[3]) + T_W'(s0_m[4]) - T_W'(s0_m[5]);
      s1_t[2] <= T_W'(s0_m[6]) - T_W'(s0_m[7]) + T_W'(s0_m[8]);
      s1_t[3] <= T_W'(s0_m[9]) + T_W'(s0_m[10]) - T_W'(s0_m[11]);
      s1_s    <= S_W'($unsigned(s0_sq[0])) + S_W'($unsigned(s0_sq[1]))
               + S_W'($unsigned(s0_sq[2])) + S_W'($unsigned(s0_sq[3]));
    end
  end

  // stage 2: t * conj(q) products, row per output component
  logic signed [TQ_W-1:0] s2_m [0:2][0:3];
  logic [S_W-1:0]         s2_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_s       <= s1_s;
      s2_m[0][0] <= s1_t[0] * s1_q[1];
      s2_m[0][1] <= s1_t[1] * s1_q[0];
      s2_m[0][2] <= s1_t[2] * s1_q[3];
      s2_m[0][3] <= s1_t[3] * s1_q[2];
      s2_m[1][0] <= s1_t[0] * s1_q[2];
      s2_m[1][1] <= s1_t[1] * s1_q[3];
      s2_m[1][2] <= s1_t[2] * s1_q[0];
      s2_m[1][3] <= s1_t[3] * s1_q[1];
      s2_m[2][0] <= s1_t[0] * s1_q[3];
      s2_m[2][1] <= s1_t[1] * s1_q[2];
      s2_m[2][2] <= s1_t[2] * s1_q[1];
      s2_m[2][3] <= s1_t[3] * s1_q[0];
    end
  end

  // stage 3: vector part P
  logic signed [P_W-1:0] s3_p [0:2];
  logic [S_W-1:0]        s3_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_s    <= s2_s;
      s3_p[0] <= -P_W'(s2_m[0][0]) + P_W'(s2_m[0][1]) - P_W'(s2_m[0][2]) + P_W'(s2_m[0][3]);
      s3_p[1] <= -P_W'(s2_m[1][0]) + P_W'(s2_m[1][1]) + P_W'(s2_m[1][2]) - P_W'(s2_m[1][3]);
      s3_p[2] <= -P_W'(s2_m[2][0]) - P_W'(s2_m[2][1]) + P_W'(s2_m[2][2]) + P_W'(s2_m[2][3]);
    end
  end

  // root pipeline; sign/magnitude of P and the zero flag ride along
  logic [SQN_W-1:0]  sq_n    [0:SQ_STEPS];
  logic [REM_W-1:0]  sq_rem  [0:SQ_STEPS];
  logic [ROOT_W-1:0] sq_root [0:SQ_STEPS];
  logic [MAG_W-1:0]  sq_mag  [0:SQ_STEPS][0:2];
  logic [2:0]        sq_neg  [0:SQ_STEPS];
  logic              sq_zero [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n[0]    <= SQN_W'({s3_s, {(2 * LEN_FRAC){1'b0}}});
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_zero[0] <= (s3_s == '0);
      for (int l = 0; l < 3; l++) begin
        sq_neg[0][l] <= s3_p[l][P_W-1];
        sq_mag[0][l] <= s3_p[l][P_W-1] ? MAG_W'(-s3_p[l]) : MAG_W'(s3_p[l]);
      end
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign rem_sh = {sq_rem[k][REM_W-3:0], sq_n[k][SQN_W-1 -: 2]};
    assign trial  = REM_W'({sq_root[k], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n[k+1]    <= {sq_n[k][SQN_W-3:0], 2'b00};
        sq_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
        sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], ge};
        sq_zero[k+1] <= sq_zero[k];
        sq_neg[k+1]  <= sq_neg[k];
        for (int l = 0; l < 3; l++) sq_mag[k+1][l] <= sq_mag[k][l];
      end
    end
  end

  // divider: setup stage checks for quotients that cannot fit, then
  // one quotient bit per stage, MSB first
  logic [DEN_W-1:0] dv_den  [0:OUT_W];
  logic [DIV_W-1:0] dv_rem  [0:OUT_W][0:2];
  logic [OUT_W-1:0] dv_quo  [0:OUT_W][0:2];
  logic [2:0]       dv_ovf  [0:OUT_W];
  logic [2:0]       dv_neg  [0:OUT_W];
  logic             dv_zero [0:OUT_W];

  logic [DEN_W-1:0] den_in;
  assign den_in = {sq_root[SQ_STEPS], {QUAT_FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_den[0]  <= den_in;
      dv_neg[0]  <= sq_neg[SQ_STEPS];
      dv_zero[0] <= sq_zero[SQ_STEPS];
      for (int l = 0; l < 3; l++) begin
        dv_rem[0][l] <= DIV_W'({sq_mag[SQ_STEPS][l], {LEN_FRAC{1'b0}}});
        dv_quo[0][l] <= '0;
        dv_ovf[0][l] <= DIV_W'({sq_mag[SQ_STEPS][l], {LEN_FRAC{1'b0}}})
                        >= DIV_W'({den_in, {OUT_W{1'b0}}});
      end
    end
  end

  for (genvar j = 0; j < OUT_W; j++) begin : g_div
    localparam int SH = OUT_W - 1 - j;
    logic [DIV_W-1:0] dsh;
    logic [2:0]       ge;

    assign dsh = DIV_W'(dv_den[j]) << SH;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      assign ge[l] = dv_rem[j][l] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_den[j+1]  <= dv_den[j];
        dv_ovf[j+1]  <= dv_ovf[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_zero[j+1] <= dv_zero[j];
        for (int l = 0; l < 3; l++) begin
          dv_rem[j+1][l] <= ge[l] ? dv_rem[j][l] - dsh : dv_rem[j][l];
          dv_quo[j+1][l] <= {dv_quo[j][l][OUT_W-2:0], ge[l]};
        end
      end
    end
  end

  // round half away from zero, restore sign, saturate
  logic signed [OUT_W-1:0] res [0:2];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic          up;
      logic [OUT_W:0] qr;
      logic [OUT_W:0] nq;
      up = {dv_rem[OUT_W][l][DEN_W-1:0], 1'b0} >= {1'b0, dv_den[OUT_W]};
      qr = {1'b0, dv_quo[OUT_W][l]} + (OUT_W + 1)'(up);
      nq = '0;
      if (dv_zero[OUT_W]) begin
        res[l] = '0;
      end else if (dv_neg[OUT_W][l]) begin
        if (dv_ovf[OUT_W][l] || qr > SAT_NEG_MAG) nq = (OUT_W + 1)'(0) - SAT_NEG_MAG;
        else nq = (OUT_W + 1)'(0) - qr;
        res[l] = nq[OUT_W-1:0];
      end else if (dv_ovf[OUT_W][l] || qr > SAT_POS) begin
        res[l] = SAT_POS[OUT_W-1:0];
      end else begin
        res[l] = qr[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x      <= res[0];
      out_y      <= res[1];
      out_z      <= res[2];
      degenerate <= dv_zero[OUT_W];
    end
  end

`ifndef NO_ASSERTIONS
  // a frozen pipe keeps its occupancy
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> vld[ST_SQ0] == $past(vld[ST_SQ0]) && out_valid)
    else $error("pipeline moved during a stall");

  // any nonzero quaternion has S >= 1, so the root is at least 2^LEN_FRAC
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    vld[ST_DV0 - 1] && !sq_zero[SQ_STEPS] |-> sq_root[SQ_STEPS] >= ROOT_W'(1 << LEN_FRAC))
    else $error("square root below unit length");

  // lane 0 divider remainder must end below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[ST_LAST - 1] && !dv_zero[OUT_W] && !dv_ovf[OUT_W][0]
    |-> dv_rem[OUT_W][0] < DIV_W'(dv_den[OUT_W]))
    else $error("divider remainder out of range");

  // degenerate results carry zero vectors
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("degenerate result with nonzero vector");
`endif

endmodule

// ----- test/quaternion_vector_rotate_checker.sv -----
// Checker for the quaternion vector rotate unit: watches both channels,
// predicts each rotated vector and compares. Depends on qvr_pkg.
`timescale 1ns / 100ps
module quaternion_vector_rotate_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [qvr_pkg::QUAT_W-1:0]   quat_w,
  input  logic signed [qvr_pkg::QUAT_W-1:0]   quat_x,
  input  logic signed [qvr_pkg::QUAT_W-1:0]   quat_y,
  input  logic signed [qvr_pkg::QUAT_W-1:0]   quat_z,
  input  logic signed [qvr_pkg::VEC_IN_W-1:0] vec_x,
  input  logic signed [qvr_pkg::VEC_IN_W-1:0] vec_y,
  input  logic signed [qvr_pkg::VEC_IN_W-1:0] vec_z,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [qvr_pkg::OUT_W-1:0]    out_x,
  input  logic signed [qvr_pkg::OUT_W-1:0]    out_y,
  input  logic signed [qvr_pkg::OUT_W-1:0]    out_z,
  input  logic                                degenerate,
  output int                                  fail_count,
  output int                                  pending
);
  import qvr_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    degen;
  } rot_vec_t;

  rot_vec_t rotated_q[$];

  function automatic longint vec_value(input logic [VEC_IN_W-1:0] raw);
    logic signed [VEC_EFF_W-1:0] low;
    low = raw[VEC_EFF_W-1:0];
    return longint'(low);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // |p| << 14 can reach ~2^63, so divide in 128 bits
  function automatic logic signed [OUT_W-1:0] scale_sat(input longint p,
                                                        input longint unsigned den);
    logic [127:0] mag, num, quo, rem;
    logic         neg;
    neg = p < 0;
    mag = neg ? 128'(-p) : 128'(p);
    num = mag << LEN_FRAC;
    quo = num / den;
    rem = num % den;
    if (2 * rem >= den) quo++;
    if (neg) begin
      if (quo > 128'd131072) quo = 128'd131072;
      return OUT_W'(-quo);
    end
    if (quo > 128'd131071) quo = 128'd131071;
    return OUT_W'(quo);
  endfunction

  function automatic rot_vec_t rotate_vec(input longint w, x, y, z, vx, vy, vz);
    rot_vec_t r;
    longint unsigned s, den;
    longint tw, tx, ty, tz, px, py, pz;
    s = w * w + x * x + y * y + z * z;
    if (s == 0) return '{x: '0, y: '0, z: '0, degen: 1'b1};
    tw = -x * vx - y * vy - z * vz;
    tx = w * vx + y * vz - z * vy;
    ty = w * vy - x * vz + z * vx;
    tz = w * vz + x * vy - y * vx;
    px = -tw * x + tx * w - ty * z + tz * y;
    py = -tw * y + tx * z + ty * w - tz * x;
    pz = -tw * z - tx * y + ty * x + tz * w;
    den = root_floor(s << (2 * LEN_FRAC)) << QUAT_FRAC_BITS;
    r.x = scale_sat(px, den);
    r.y = scale_sat(py, den);
    r.z = scale_sat(pz, den);
    r.degen = 1'b0;
    return r;
  endfunction

  assign pending = rotated_q.size();

  always @(posedge clk) begin
    rot_vec_t exp_v;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        rotated_q.push_back(rotate_vec(quat_w, quat_x, quat_y, quat_z,
                                       vec_value(vec_x), vec_value(vec_y),
                                       vec_value(vec_z)));
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected transfer x=%0d y=%0d z=%0d d=%0b",
                   $time, out_x, out_y, out_z, degenerate);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = rotated_q.pop_front();
          if (out_x !== exp_v.x || out_y !== exp_v.y || out_z !== exp_v.z ||
              degenerate !== exp_v.degen) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d d=%0b, got x=%0d y=%0d z=%0d d=%0b",
                     $time, exp_v.x, exp_v.y, exp_v.z, exp_v.degen,
                     out_x, out_y, out_z, degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- test/quaternion_vector_rotate_unit_test.sv -----
// Testbench top for quaternion_vector_rotate_unit: directed and random
// stimulus with bursty input and stalling output. Depends on qvr_pkg and
// quaternion_vector_rotate_checker.
`timescale 1ns / 100ps
module quaternion_vector_rotate_unit_test;
  import qvr_pkg::*;

  localparam int N_RANDOM   = 1950;
  localparam int IDLE_LIMIT = 4000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, degenerate;
  logic signed [QUAT_W-1:0]   quat_w, quat_x, quat_y, quat_z;
  logic signed [VEC_IN_W-1:0] vec_x, vec_y, vec_z;
  logic signed [OUT_W-1:0]    out_x, out_y, out_z;
  int   fail_count, pending, idle_cycles;
  bit   long_hold;

  quaternion_vector_rotate_unit i_dut (.*);

  quaternion_vector_rotate_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall pattern, plus one long hold-off on request
  initial begin
    int mode;
    bit hold_done;
    out_ready = 0;
    hold_done = 0;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold && !hold_done) begin
        out_ready <= 0;
        repeat (150) @(posedge clk);
        hold_done = 1;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [15:0] w, x, y, z, vx, vy, vz);
    in_valid <= 1'b1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    vec_x <= vx; vec_y <= vy; vec_z <= vz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // mostly near-unit quaternions so outputs stay in range
  task automatic send_random();
    logic signed [15:0] q[4];
    int c;
    if ($urandom_range(0, 3) == 0) begin
      foreach (q[i]) q[i] = rand_field();
    end else begin
      foreach (q[i]) q[i] = 16'($urandom_range(0, 16384) - 8192);
      c = $urandom_range(0, 3);
      q[c] = $urandom_range(0, 1) ? 16'sd16384 - q[c] / 4 : -16'sd16384 + q[c] / 4;
    end
    send_item(q[0], q[1], q[2], q[3], rand_field(), rand_field(), rand_field());
  endtask

  initial begin
    int sent;
    rst = 1; in_valid = 0; long_hold = 0;
    quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
    vec_x = 0; vec_y = 0; vec_z = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // identity, axis rotations, zero quaternion, extremes, saturation
    send_item(16'd16384, 0, 0, 0, 16'd100, -16'sd200, 16'd300);
    send_item(0, 16'd16384, 0, 0, 16'd1, 16'd2, 16'd3);
    send_item(0, 0, 16'd16384, 0, 16'h7FFF, 16'h8000, 16'd5);
    send_item(0, 0, 0, 16'd16384, 16'h8000, 16'h7FFF, 16'h8000);
    send_item(16'd11585, 0, 0, 16'd11585, 16'd1000, 0, 0);
    send_item(0, 0, 0, 0, 16'd7, 16'd8, 16'd9);
    send_item(0, 0, 0, 0, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(16'h8000, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000);
    send_item(16'd1, 0, 0, 0, 16'd3, -16'sd3, 16'd1);
    send_item(0, 16'd1, 16'd1, 0, 16'd1, 0, 0);
    send_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
    send_item(16'd8192, 16'd8192, 16'd8192, 16'd8192, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // wait for the pipe to drain
    in_valid <= 1'b0;
    @(posedge clk iff pending == 0);
    // block fills and back-pressures while the receiver holds off
    long_hold = 1;
    for (int i = 0; i < 120; i++) send_random();
    sent = 120;
    while (sent < N_RANDOM) begin
      repeat ($urandom_range(1, 30)) begin
        send_random();
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    in_valid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (N_STG + 10) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- quaternion_vector_rotate_unit.f -----
hw/rtl/qvr_pkg.sv
hw/rtl/quaternion_vector_rotate_unit.sv
test/quaternion_vector_rotate_checker.sv
test/quaternion_vector_rotate_unit_test.sv
